// ----- rtl/prsf_pkg.sv -----
package prsf_pkg;

    localparam int REC_SAMPLES = 2048;
    localparam int SEG1_END    = 1005;
    localparam int SEG2_END    = 2026;
    localparam int SEG2_LEN    = SEG2_END - SEG1_END;
    localparam int SEG3_LEN    = REC_SAMPLES - SEG2_END;

    localparam int POS_W   = 12;
    localparam int CNT_W   = 32;
    localparam int WORD_W  = 16;
    localparam int REP_W   = 12;
    localparam int RUN_W   = 11;
    localparam int STEP_W  = 5;
    localparam int KEY_WORDS = 14;
    localparam int KEY_W   = KEY_WORDS * WORD_W;
    localparam int HDR_LEN = KEY_WORDS + 3;

    typedef logic [1:0] op_t;
    localparam op_t OP_SAMPLE = 2'd0;
    localparam op_t OP_CLOSE  = 2'd1;
    localparam op_t OP_START  = 2'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KEY_LO   = 2'd0;
    localparam cfg_idx_t CFG_KEY_MID  = 2'd1;
    localparam cfg_idx_t CFG_KEY_HIGH = 2'd2;
    localparam cfg_idx_t CFG_KEY_TAIL = 2'd3;

    localparam logic [WORD_W-1:0] CTRL_FIRST  = 16'h0001;
    localparam logic [WORD_W-1:0] CTRL_MIDDLE = 16'h0000;
    localparam logic [WORD_W-1:0] CTRL_LAST   = 16'h0002;

    // close sequence steps
    localparam logic [2:0] CL_RUN_A  = 3'd0;
    localparam logic [2:0] CL_MID    = 3'd1;
    localparam logic [2:0] CL_RUN_B  = 3'd2;
    localparam logic [2:0] CL_LAST   = 3'd3;
    localparam logic [2:0] CL_RUN_C  = 3'd4;
    localparam logic [2:0] CL_CNT_LO = 3'd5;
    localparam logic [2:0] CL_CNT_HI = 3'd6;

    typedef struct packed {
        logic               close;
        logic               hdr;
        logic               hdr_before;
        logic               ctrl_last;
        logic [STEP_W-1:0]  step;
        logic [STEP_W-1:0]  final_step;
        logic [WORD_W-1:0]  sample;
        logic [RUN_W-1:0]   run;
        logic [2:0]         start;
        logic [CNT_W-1:0]   cnt;
    } job_t;

endpackage

// ----- rtl/pcm_record_segment_framer_unit.sv -----
// Record framer for a 16-bit PCM sample stream.
// Input channel s_*: tuser carries the operation (sample, close, start),
// tdata the signed sample. Output channel m_*: tdata carries the word and
// its repeat count, tuser the kind (append or count patch), tlast marks the
// final result of an input item. Key registers are written on cfg_*.
// Each accepted item is held in a job register that emits one result per
// cycle into the output register while the output is not stalled; each
// result is registered from the job register into the output register.
// A plain sample gives one result, so the block takes one sample per cycle
// while the output is not stalled. At segment and record boundaries the
// header words are walked by the step counter of the job register, as are the close steps.
// A start or an unused code is taken without a job and gives no result.
// When m_tready is low with the output register full, the output register holds,
// the job register holds, and s_tready drops once the job register is occupied.
// Reset clears the key registers, the entry count and the valid flags, and
// sets the record position to await the first header.
module pcm_record_segment_framer_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] sample
    input  logic [1:0]                   s_tuser,   // [1:0] operation
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [15:0] word, [27:16] repeat_res, zero pad
    output logic                         m_tuser,   // [0] kind
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [63:0]                  cfg_data
);
    import prsf_pkg::*;

    logic [63:0]        key_lo_reg, key_mid_reg, key_high_reg;
    logic [31:0]        key_tail_reg;
    logic [KEY_W-1:0]   key_all;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    job_t               job_reg, job_new;
    logic               job_valid_reg;
    logic               new_job;
    logic               adv, job_last, s_acc;
    logic               m_tvalid_reg;
    logic [WORD_W-1:0]  word_reg, res_word;
    logic [REP_W-1:0]   rep_reg, res_rep;
    logic               kind_reg, res_kind;
    logic               last_reg;
    logic               is_sample;
    logic [STEP_W-1:0]  hdr_idx;

    function automatic logic [WORD_W-1:0] hdr_word(input logic [STEP_W-1:0] idx,
                                                   input logic [KEY_W-1:0] key);
        logic [STEP_W-1:0] kidx;
        kidx = idx - STEP_W'(1);
        if (idx == '0)
            return CTRL_FIRST;
        else if (idx <= STEP_W'(KEY_WORDS))
            return key[kidx[3:0]*WORD_W +: WORD_W];
        else
            return '0;
    endfunction

    assign key_all   = {key_tail_reg, key_high_reg, key_mid_reg, key_lo_reg};
    assign cfg_ready = 1'b1;

    assign job_last = job_reg.step == job_reg.final_step;
    assign adv      = job_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !job_valid_reg || (adv && job_last);
    assign s_acc    = s_tvalid && s_tready;

    always_comb
    begin
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        new_job  = 1'b0;
        job_new  = '0;
        job_new.sample = s_tdata;
        job_new.cnt    = cnt_reg;
        unique case (s_tuser)
            OP_SAMPLE:
            begin
                new_job  = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                job_new.cnt = cnt_next;
                priority if (pos_reg == POS_W'(REC_SAMPLES))
                begin
                    job_new.hdr        = 1'b1;
                    job_new.hdr_before = 1'b1;
                    job_new.final_step = STEP_W'(HDR_LEN);
                    pos_next = POS_W'(1);
                end
                else if (pos_reg == POS_W'(REC_SAMPLES - 1))
                begin
                    job_new.hdr        = 1'b1;
                    job_new.final_step = STEP_W'(HDR_LEN);
                    pos_next = '0;
                end
                else if (pos_reg == POS_W'(SEG1_END - 1))
                begin
                    job_new.final_step = STEP_W'(1);
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (pos_reg == POS_W'(SEG2_END - 1))
                begin
                    job_new.ctrl_last  = 1'b1;
                    job_new.final_step = STEP_W'(1);
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            OP_CLOSE:
            begin
                new_job = 1'b1;
                job_new.close      = 1'b1;
                job_new.final_step = STEP_W'(CL_CNT_HI);
                pos_next = '0;
                priority if (pos_reg < POS_W'(SEG1_END))
                begin
                    job_new.start = CL_RUN_A;
                    job_new.run   = RUN_W'(POS_W'(SEG1_END) - pos_reg);
                end
                else if (pos_reg < POS_W'(SEG2_END))
                begin
                    job_new.start = CL_RUN_B;
                    job_new.run   = RUN_W'(POS_W'(SEG2_END) - pos_reg);
                end
                else if (pos_reg < POS_W'(REC_SAMPLES))
                begin
                    job_new.start = CL_RUN_C;
                    job_new.run   = RUN_W'(POS_W'(REC_SAMPLES) - pos_reg);
                end
                else
                begin
                    job_new.start = CL_CNT_LO;
                    pos_next = pos_reg;
                end
                job_new.step = STEP_W'(job_new.start);
            end
            OP_START:
            begin
                pos_next = POS_W'(REC_SAMPLES);
                cnt_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign is_sample = job_reg.hdr_before ? job_last : (job_reg.step == '0);
    assign hdr_idx   = job_reg.hdr_before ? job_reg.step : job_reg.step - STEP_W'(1);

    always_comb
    begin
        res_word = '0;
        res_rep  = REP_W'(1);
        res_kind = 1'b0;
        if (job_reg.close)
        begin
            unique case (job_reg.step[2:0])
                CL_RUN_A: res_rep = REP_W'(job_reg.run);
                CL_MID:   res_word = CTRL_MIDDLE;
                CL_RUN_B: res_rep = (job_reg.start == CL_RUN_B) ? REP_W'(job_reg.run)
                                                                : REP_W'(SEG2_LEN);
                CL_LAST:  res_word = CTRL_LAST;
                CL_RUN_C: res_rep = (job_reg.start == CL_RUN_C) ? REP_W'(job_reg.run)
                                                                : REP_W'(SEG3_LEN);
                CL_CNT_LO:
                begin
                    res_word = job_reg.cnt[WORD_W-1:0];
                    res_kind = 1'b1;
                end
                CL_CNT_HI:
                begin
                    res_word = job_reg.cnt[CNT_W-1:WORD_W];
                    res_kind = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (is_sample)
            res_word = job_reg.sample;
        else if (job_reg.hdr)
            res_word = hdr_word(hdr_idx, key_all);
        else
            res_word = job_reg.ctrl_last ? CTRL_LAST : CTRL_MIDDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg    <= '0;
            key_mid_reg   <= '0;
            key_high_reg  <= '0;
            key_tail_reg  <= '0;
            pos_reg       <= POS_W'(REC_SAMPLES);
            cnt_reg       <= '0;
            job_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_KEY_LO:   key_lo_reg   <= cfg_data;
                    CFG_KEY_MID:  key_mid_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_TAIL: key_tail_reg <= cfg_data[31:0];
                endcase
            end
            if (s_acc)
            begin
                pos_reg <= pos_next;
                cnt_reg <= cnt_next;
            end
            if (s_acc && new_job)
                job_valid_reg <= 1'b1;
            else if (adv && job_last)
                job_valid_reg <= 1'b0;
            if (adv)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && new_job)
            job_reg <= job_new;
        else if (adv && !job_last)
            job_reg.step <= job_reg.step + STEP_W'(1);
        if (adv)
        begin
            word_reg <= res_word;
            rep_reg  <= res_rep;
            kind_reg <= res_kind;
            last_reg <= job_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, rep_reg, word_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
